FILE: rtl/lzwc_pkg.sv
// package: constants, payload types and controller command/status structs for the lzw compressor
package lzwc_pkg;

  localparam int MAX_CODES  = 4096;
  localparam int HASH_SLOTS = 8192;
  localparam int FIRST_CODE = 256;

  localparam int CODE_W = 12;
  localparam int BYTE_W = 8;
  localparam int HASH_W = $clog2(HASH_SLOTS);
  localparam int NFC_W  = $clog2(MAX_CODES) + 1;
  localparam int SLOT_W = 1 + CODE_W + BYTE_W + CODE_W;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              end_of_stream;
  } out_beat_t;

  typedef struct packed {
    logic clr_wr;
    logic take_in;
    logic start_match;
    logic home;
    logic probe_next;
    logic hit_take;
    logic insert;
    logic emit_miss;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic match_active;
    logic last;
    logic slot_valid;
    logic key_eq;
    logic probe_full;
    logic room;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/lzwc_ram.sv
// generic single-write, single-read ram with registered read data
module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/lzwc_datapath.sv
// datapath: match registers, hash, probe index, dictionary ram, output register
module lzwc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  lzwc_pkg::cmd_t      cmd,
  output lzwc_pkg::sts_t      sts,
  input  lzwc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lzwc_pkg::out_beat_t out_data
);

  localparam int CW = lzwc_pkg::CODE_W;
  localparam int BW = lzwc_pkg::BYTE_W;
  localparam int HW = lzwc_pkg::HASH_W;

  logic [BW-1:0]             byte_r;
  logic                      last_r;
  logic [CW-1:0]             match_r, match_nxt;
  logic                      active_r, active_nxt;
  logic [lzwc_pkg::NFC_W-1:0] nfc_r, nfc_nxt;
  logic [31:0]               prod_r;
  logic [31:0]               fold;
  logic [HW-1:0]             idx_r;
  logic [HW-1:0]             cnt_r;
  logic [HW:0]               clr_r;
  logic                      out_valid_r, out_valid_nxt;
  lzwc_pkg::out_beat_t       out_r, out_nxt;
  logic [31:0]               key;

  logic                      wr_en;
  logic [HW-1:0]             wr_addr;
  logic [lzwc_pkg::SLOT_W-1:0] wr_data, rd_data;

  assign key  = {{(32-CW-BW){1'b0}}, match_r, byte_r};
  assign fold = prod_r ^ (prod_r >> 15);

  // slot: valid, prefix, byte, code
  assign wr_en   = cmd.clr_wr | cmd.insert;
  assign wr_addr = cmd.clr_wr ? clr_r[HW-1:0] : idx_r;
  assign wr_data = cmd.clr_wr ? '0 : {1'b1, match_r, byte_r, nfc_r[CW-1:0]};

  lzwc_ram #(.WIDTH(lzwc_pkg::SLOT_W), .DEPTH(lzwc_pkg::HASH_SLOTS)) u_dict (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  always_comb begin
    match_nxt     = match_r;
    active_nxt    = active_r;
    nfc_nxt       = nfc_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_nxt       = out_r;
    if (cmd.start_match) begin
      match_nxt  = byte_r;
      active_nxt = 1'b1;
    end
    if (cmd.hit_take) begin
      match_nxt = rd_data[CW-1:0];
    end
    if (cmd.insert) begin
      nfc_nxt = nfc_r + 1'b1;
    end
    if (cmd.emit_miss) begin
      out_nxt       = '{code: match_r, end_of_stream: 1'b0};
      out_valid_nxt = 1'b1;
      match_nxt     = byte_r;
    end
    if (cmd.emit_last) begin
      out_nxt       = '{code: match_r, end_of_stream: 1'b1};
      out_valid_nxt = 1'b1;
      match_nxt     = '0;
      active_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r     <= '0;
      active_r    <= 1'b0;
      nfc_r       <= lzwc_pkg::NFC_W'(lzwc_pkg::FIRST_CODE);
      out_valid_r <= 1'b0;
      clr_r       <= '0;
    end else begin
      match_r     <= match_nxt;
      active_r    <= active_nxt;
      nfc_r       <= nfc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.clr_wr) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    prod_r <= key * lzwc_pkg::HASH_MULT;
    if (cmd.take_in) begin
      byte_r <= in_data.data_byte;
      last_r <= in_data.last_byte;
    end
    if (cmd.home) begin
      idx_r <= fold[HW-1:0];
      cnt_r <= '0;
    end else if (cmd.probe_next) begin
      idx_r <= idx_r + 1'b1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sts.clr_done     = clr_r[HW];
  assign sts.match_active = active_r;
  assign sts.last         = last_r;
  assign sts.slot_valid   = rd_data[lzwc_pkg::SLOT_W-1];
  assign sts.key_eq       = rd_data[lzwc_pkg::SLOT_W-2:CW] == {match_r, byte_r};
  assign sts.probe_full   = cnt_r == HW'(lzwc_pkg::HASH_SLOTS - 1);
  assign sts.room         = nfc_r < lzwc_pkg::NFC_W'(lzwc_pkg::MAX_CODES);
  assign sts.out_free     = ~out_valid_r | ~out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/lzwc_ctrl.sv
// controller: sequences clear sweep, hash lookup, probing, insert and emission
module lzwc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lzwc_pkg::sts_t sts,
  output lzwc_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_START     = 3'd2;
  localparam logic [2:0] ST_HOME      = 3'd3;
  localparam logic [2:0] ST_READ      = 3'd4;
  localparam logic [2:0] ST_CHECK     = 3'd5;
  localparam logic [2:0] ST_EMIT_MISS = 3'd6;
  localparam logic [2:0] ST_EMIT_LAST = 3'd7;

  logic [2:0] state_r, state_nxt;

  assign in_stall = state_r != ST_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.clr_wr = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = ST_START;
        end
      end
      ST_START: begin
        if (!sts.match_active) begin
          cmd.start_match = 1'b1;
          state_nxt       = sts.last ? ST_EMIT_LAST : ST_IDLE;
        end else begin
          state_nxt = ST_HOME;
        end
      end
      ST_HOME: begin
        cmd.home  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!sts.slot_valid) begin
          cmd.insert = sts.room;
          state_nxt  = ST_EMIT_MISS;
        end else if (sts.key_eq) begin
          cmd.hit_take = 1'b1;
          state_nxt    = sts.last ? ST_EMIT_LAST : ST_IDLE;
        end else if (sts.probe_full) begin
          state_nxt = ST_EMIT_MISS;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = ST_READ;
        end
      end
      ST_EMIT_MISS: begin
        if (sts.out_free) begin
          cmd.emit_miss = 1'b1;
          state_nxt     = sts.last ? ST_EMIT_LAST : ST_IDLE;
        end
      end
      ST_EMIT_LAST: begin
        if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/lzw_compressor_12bit_unit.sv
// top level of the 12-bit lzw compressor: controller plus datapath
//
//   channel | direction | payload                          | handshake
//   in_     | input     | data_byte[7:0], last_byte        | in_valid / in_stall
//   out_    | output    | code[11:0], end_of_stream        | out_valid / out_stall
//
// first byte of a stream: take and start only; other bytes: take, start, home, read, check,
//   plus read, check per extra probe; set by the registered hash multiply and dictionary read
// a miss adds an emit step, a last byte a further flush step
// after reset a clearing pass writes all 8192 dictionary slots with in_stall high
// out_stall only holds the one-beat output register; a new byte is taken while a beat waits,
//   the block pauses only when it must emit into a still-full output register
module lzw_compressor_12bit_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lzwc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lzwc_pkg::out_beat_t out_data
);

  // command and status between the two halves
  lzwc_pkg::cmd_t cmd;
  lzwc_pkg::sts_t sts;

  lzwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // dictionary, match state and output beat register live here
  lzwc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
